### hw/rtl/sequential_list_insert_defines.svh
// assertion macros shared by the list insert checker
`ifndef SEQUENTIAL_LIST_INSERT_DEFINES_SVH
`define SEQUENTIAL_LIST_INSERT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/slins_pkg.sv
// shared types and constants of the list insert block
package slins_pkg;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int STAT_W   = 2;
  localparam int CNTO_W   = 8;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;
  localparam int TREE_LAT = 3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  // write command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic [DATA_W-1:0] value;
  } wr_t;

endpackage

### hw/rtl/slins_cell.sv
// one list cell: holds one element, shifts in from its lower neighbor on insert
module slins_cell #(
  parameter int IW  = 7,
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  slins_pkg::wr_t               wr,
  input  logic [IW-1:0]                ins_idx,
  input  logic [IW-1:0]                rd_idx,
  input  logic [slins_pkg::DATA_W-1:0] left_data,
  output logic [slins_pkg::DATA_W-1:0] data_o,
  output logic [slins_pkg::DATA_W-1:0] rd_o
);
  import slins_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (wr.ins) begin
      if (MY_IDX > ins_idx) begin
        data_nxt = left_data;
      end else if (MY_IDX == ins_idx) begin
        data_nxt = wr.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // only the addressed cell puts its word on the read tree
  assign rd_o   = (rd_idx == MY_IDX) ? data_r : '0;

endmodule

### hw/rtl/slins_rdtree.sv
// registered or-reduction tree that gathers the addressed cell word
module slins_rdtree #(
  parameter int N = 128
) (
  input  logic                         clk,
  input  logic [slins_pkg::DATA_W-1:0] din [N],
  output logic [slins_pkg::DATA_W-1:0] dout
);
  import slins_pkg::*;

  localparam int FAN = 16;
  localparam int L1  = (N + FAN - 1) / FAN;
  localparam int L2  = (L1 + FAN - 1) / FAN;

  logic [DATA_W-1:0] l1_r   [L1];
  logic [DATA_W-1:0] l1_nxt [L1];
  logic [DATA_W-1:0] l2_r   [L2];
  logic [DATA_W-1:0] l2_nxt [L2];
  logic [DATA_W-1:0] root_r;
  logic [DATA_W-1:0] root_nxt;

  always_comb begin
    for (int g = 0; g < L1; g++) begin
      l1_nxt[g] = '0;
      for (int j = 0; j < FAN; j++) begin
        if (g * FAN + j < N) begin
          l1_nxt[g] = l1_nxt[g] | din[g * FAN + j];
        end
      end
    end
  end

  always_comb begin
    for (int g = 0; g < L2; g++) begin
      l2_nxt[g] = '0;
      for (int j = 0; j < FAN; j++) begin
        if (g * FAN + j < L1) begin
          l2_nxt[g] = l2_nxt[g] | l1_r[g * FAN + j];
        end
      end
    end
  end

  always_comb begin
    root_nxt = '0;
    for (int g = 0; g < L2; g++) begin
      root_nxt = root_nxt | l2_r[g];
    end
  end

  always_ff @(posedge clk) begin
    l1_r   <= l1_nxt;
    l2_r   <= l2_nxt;
    root_r <= root_nxt;
  end

  assign dout = root_r;

endmodule

### hw/rtl/sequential_list_insert.sv
// top level of the fixed-capacity ordered list with insert and read
// A list of up to CAPACITY signed 32-bit words kept in a row of cells, one word per
// cell. An insert word (mode 0) puts value at 1-based position and every cell above
// that position takes its lower neighbor's word in the same cycle, so an insert
// result is in the output register on the next cycle. A read word (mode 1) with a
// good position is gathered from the cells through a three-level registered or-tree
// (sixteen inputs per node); its result passes the read index register, the three
// tree levels and the output register, and the block takes no new word meanwhile.
// Bad positions and full-list inserts answer without the tree and leave the list as
// it was. A new word is taken when the block is idle and the output register is
// empty or being drained. Cell contents need no clearing after reset: only positions
// up to the current length can be read. count reports the low 8 bits of the length.
module sequential_list_insert #(
  parameter int CAPACITY = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // mode [0], position [8:1], value [40:9], zero [47:41]
  input  logic [slins_pkg::IN_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status [1:0], read_value [33:2], count [41:34], zero [47:42]
  output logic [slins_pkg::OUT_W-1:0] out_tdata
);
  import slins_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // wide enough for both position and length plus one
  localparam int XW = (CW > POS_W) ? CW + 1 : POS_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_RES  = 3'b100
  } state_t;

  // input word fields
  logic              in_mode;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_value;

  assign in_mode  = in_tdata[0];
  assign in_pos   = in_tdata[POS_W:1];
  assign in_value = in_tdata[POS_W + DATA_W:POS_W + 1];

  state_t            state_r, state_nxt;
  logic [1:0]        wait_r, wait_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_rdval_r, out_rdval_nxt;
  logic [CNTO_W-1:0] out_count_r, out_count_nxt;

  logic              in_acc;
  logic              out_free;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic [IW-1:0]     pos_idx;
  logic              ins_bad;
  logic              rd_bad;
  logic              is_full;
  wr_t               wr;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] tree_out;

  // output register is free when empty or drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // position checks against the current length
  assign pos_x   = XW'(in_pos);
  assign cnt_x   = XW'(count_r);
  assign pos_idx = IW'(pos_x - XW'(1));
  assign ins_bad = (in_pos == '0) || (pos_x > (cnt_x + XW'(1)));
  assign rd_bad  = (in_pos == '0) || (pos_x > cnt_x);
  assign is_full = (count_r == CW'(CAPACITY));

  always_comb begin
    state_nxt      = state_r;
    wait_nxt       = wait_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_rdval_nxt  = out_rdval_r;
    out_count_nxt  = out_count_r;
    wr.ins         = 1'b0;
    wr.value       = in_value;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_INSERT) begin
            out_valid_nxt = 1'b1;
            out_rdval_nxt = '0;
            if (ins_bad) begin
              out_status_nxt = ST_BADPOS;
            end else if (is_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              // cells above the position shift and the cell at it takes value, this cycle
              out_status_nxt = ST_OK;
              wr.ins         = 1'b1;
              count_nxt      = count_r + CW'(1);
            end
            out_count_nxt = CNTO_W'(count_nxt);
          end else if (rd_bad) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_BADPOS;
            out_rdval_nxt  = '0;
            out_count_nxt  = CNTO_W'(count_r);
          end else begin
            // good read: select the cell and wait for the tree
            rd_idx_nxt = pos_idx;
            wait_nxt   = '0;
            state_nxt  = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (wait_r == 2'(TREE_LAT - 1)) begin
          state_nxt = S_RES;
        end else begin
          wait_nxt = wait_r + 2'd1;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_rdval_nxt  = tree_out;
          out_count_nxt  = CNTO_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
    out_rdval_r  <= out_rdval_nxt;
    out_count_r  <= out_count_nxt;
  end

  // row of cells, cell g holds list position g+1
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = cell_data[g - 1];
    end
    slins_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .wr        (wr),
      .ins_idx   (pos_idx),
      .rd_idx    (rd_idx_r),
      .left_data (left),
      .data_o    (cell_data[g]),
      .rd_o      (cell_rd[g])
    );
  end

  slins_rdtree #(
    .N (CAPACITY)
  ) u_rdtree (
    .clk  (clk),
    .din  (cell_rd),
    .dout (tree_out)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    (OUT_W - STAT_W - DATA_W - CNTO_W)'(0),
    out_count_r,
    out_rdval_r,
    out_status_r
  };

endmodule

### hw/rtl/slins_checker.sv
// port-level checks of the list insert block, bound to the top level
`include "sequential_list_insert_defines.svh"

module slins_checker #(
  parameter int CAPACITY = 128
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [slins_pkg::IN_W-1:0]  in_tdata,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [slins_pkg::OUT_W-1:0] out_tdata
);
  import slins_pkg::*;

  logic [STAT_W-1:0] st;
  logic [DATA_W-1:0] rdv;
  logic [CNTO_W-1:0] cnt;
  logic              in_acc;
  logic [POS_W-1:0]  in_pos;

  assign st     = out_tdata[STAT_W-1:0];
  assign rdv    = out_tdata[STAT_W + DATA_W - 1:STAT_W];
  assign cnt    = out_tdata[STAT_W + DATA_W + CNTO_W - 1:STAT_W + DATA_W];
  assign in_acc = in_tvalid && in_tready;
  assign in_pos = in_tdata[POS_W:1];

  // a stalled result word holds
  `SLI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // status is one of the three defined codes
  `SLI_ASSERT_NOW(a_status_code, out_tvalid, (st == ST_OK) || (st == ST_BADPOS) || (st == ST_FULL), "undefined status code")

  // only a successful read carries a nonzero value
  `SLI_ASSERT_NOW(a_rdval_zero, out_tvalid && (st != ST_OK), rdv == '0, "read value on a failed item")

  // a full refusal reports the list at capacity
  `SLI_ASSERT_NOW(a_full_count, out_tvalid && (st == ST_FULL), cnt == CNTO_W'(CAPACITY), "full status below capacity")

  // position zero is refused on the next cycle for either mode
  `SLI_ASSERT_NEXT(a_pos_zero, in_acc && (in_pos == '0), out_tvalid && (st == ST_BADPOS), "position zero not refused")

endmodule

bind sequential_list_insert slins_checker #(
  .CAPACITY (CAPACITY)
) u_slins_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the ordered list with positional insert and read
module tb;
  import slins_pkg::*;

  localparam int LIST_CAP      = 128;
  localparam int CYCLE_LIMIT   = 400000;
  // cycles the receiver holds off in the output stall test
  localparam int LONG_STALL    = 160;
  // settle time for stray result words, sized from the read tree depth
  localparam int SETTLE_CYCLES = 4 * (TREE_LAT + 2);

  // one result word, split into its fields
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_value;
    logic [CNTO_W-1:0] count;
  } list_result_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  // mode [0], position [8:1], value [40:9], zero [47:41]
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // status [1:0], read_value [33:2], count [41:34], zero [47:42]
  logic [OUT_W-1:0] out_tdata;

  // shadow copy of the list, kept in step with every accepted word
  logic [DATA_W-1:0] list_words [LIST_CAP];
  int unsigned       list_len = 0;

  // expected result words, oldest first
  list_result_t pending_results [$];
  list_result_t got_result;
  list_result_t want_result;

  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned inserts_sent    = 0;
  int unsigned reads_sent      = 0;
  int unsigned cycle_count     = 0;

  // idling control shared by the sender and the receiver
  bit gaps_on        = 1'b1;
  bit long_stall_req = 1'b0;

  sequential_list_insert #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // list behavior: apply one word to the shadow list, return its result
  // ---------------------------------------------------------------------------
  function automatic list_result_t apply_list_op(input logic mode,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [DATA_W-1:0] val);
    list_result_t res;
    int unsigned  k;
    res.status     = ST_OK;
    res.read_value = '0;
    if (mode == MODE_INSERT) begin
      // position check wins over the full check
      if (pos == 0 || pos > list_len + 1) begin
        res.status = ST_BADPOS;
      end else if (list_len >= LIST_CAP) begin
        res.status = ST_FULL;
      end else begin
        // everything at or above the insert point moves up one place
        for (k = list_len; k >= pos; k--) begin
          list_words[k] = list_words[k - 1];
        end
        list_words[pos - 1] = val;
        list_len++;
      end
    end else begin
      if (pos == 0 || pos > list_len) begin
        res.status = ST_BADPOS;
      end else begin
        res.read_value = list_words[pos - 1];
      end
    end
    res.count = CNTO_W'(list_len);
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  // position in [lo, hi], leaning toward both ends
  function automatic logic [POS_W-1:0] pick_in_range(input int unsigned lo,
                                                     input int unsigned hi);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 20) return POS_W'(lo);
    if (r < 40) return POS_W'(hi);
    return POS_W'($urandom_range(hi, lo));
  endfunction

  // random word; valid_pct is the share of in-range positions
  task automatic gen_random_word(input int unsigned valid_pct, output logic mode,
                                 output logic [POS_W-1:0] pos,
                                 output logic [DATA_W-1:0] val);
    int unsigned r;
    int unsigned top;
    mode = 1'($urandom_range(1, 0));
    val  = $urandom;
    r    = $urandom_range(99, 0);
    if (r < 4)       val = 32'h7FFF_FFFF;
    else if (r < 8)  val = 32'h8000_0000;
    else if (r < 10) val = '0;
    else if (r < 12) val = '1;
    // highest good position for this kind of word
    top = (mode == MODE_INSERT) ? list_len + 1 : list_len;
    if ($urandom_range(99, 0) < valid_pct && top != 0) begin
      pos = pick_in_range(1, top);
    end else if (top >= 255 || $urandom_range(3, 0) == 0) begin
      pos = '0;
    end else begin
      pos = POS_W'($urandom_range(255, top + 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: offer one word, wait for its handshake, record what it must give
  // valid stays high on return so the next word can follow without a bubble
  // ---------------------------------------------------------------------------
  task automatic send_list_word(input logic mode, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - DATA_W - POS_W - 1){1'b0}}, val, pos, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_list_op(mode, pos, val));
    if (mode == MODE_INSERT) inserts_sent++;
    else reads_sent++;
  endtask

  // sender pauses until every expected result word has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_words(input int unsigned n, input int unsigned valid_pct);
    logic              mode;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    repeat (n) begin
      gen_random_word(valid_pct, mode, pos, val);
      send_list_word(mode, pos, val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random ready gaps, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned gap;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (long_stall_req) begin
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_req = 1'b0;
      end else if (!gaps_on) begin
        out_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each accepted result word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result.status     = out_tdata[1:0];
      got_result.read_value = out_tdata[33:2];
      got_result.count      = out_tdata[41:34];
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending: status %0d count %0d",
               got_result.status, got_result.count);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        results_checked++;
        if (got_result.status !== want_result.status) begin
          $error("status: expected %0d, actual %0d", want_result.status,
                 got_result.status);
          mismatch_count++;
        end
        if (got_result.read_value !== want_result.read_value) begin
          $error("read_value: expected %0d, actual %0d",
                 $signed(want_result.read_value), $signed(got_result.read_value));
          mismatch_count++;
        end
        if (got_result.count !== want_result.count) begin
          $error("count: expected %0d, actual %0d", want_result.count,
                 got_result.count);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty list, bad positions, front, back and middle inserts, extreme values
  task automatic test_edges_directed();
    // nothing to read yet, and only position 1 may be inserted
    send_list_word(MODE_READ, 8'd0, 32'h0);
    send_list_word(MODE_READ, 8'd1, 32'h1234_5678);
    send_list_word(MODE_INSERT, 8'd0, 32'h1111_1111);
    send_list_word(MODE_INSERT, 8'd2, 32'h2222_2222);
    send_list_word(MODE_INSERT, 8'd255, 32'h3333_3333);
    // build a short list through every kind of insert point
    send_list_word(MODE_INSERT, 8'd1, 32'h7FFF_FFFF);
    send_list_word(MODE_INSERT, 8'd1, 32'h8000_0000);
    send_list_word(MODE_INSERT, 8'd3, 32'hFFFF_FFFF);
    send_list_word(MODE_INSERT, 8'd2, 32'h0000_0000);
    // one past the end plus one is refused
    send_list_word(MODE_INSERT, 8'd6, 32'h0000_0001);
    send_list_word(MODE_INSERT, 8'd5, 32'h5555_5555);
    send_list_word(MODE_INSERT, 8'd3, 32'hAAAA_AAAA);
    // read back every place plus both sides, value field carries junk
    send_list_word(MODE_READ, 8'd0, 32'hDEAD_BEEF);
    for (int p = 1; p <= 7; p++) begin
      send_list_word(MODE_READ, POS_W'(p), $urandom);
    end
    send_list_word(MODE_READ, 8'd255, 32'hFFFF_FFFF);
    wait_results_drained();
  endtask

  // mostly good positions so the list grows, with bad ones mixed in
  task automatic test_random_growth();
    send_random_words(220, 80);
    wait_results_drained();
  endtask

  // no idling on either side: inserts and reads back to back
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    send_random_words(40, 85);
    wait_results_drained();
    gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_stall();
    gaps_on        = 1'b0;
    long_stall_req = 1'b1;
    send_random_words(30, 85);
    wait_results_drained();
    gaps_on = 1'b1;
  endtask

  // grow to capacity, then probe the full list
  task automatic test_fill_to_capacity();
    while (list_len < LIST_CAP) begin
      send_list_word(MODE_INSERT, pick_in_range(1, list_len + 1), $urandom);
    end
    // good positions on a full list report full, bad ones still report bad
    send_list_word(MODE_INSERT, 8'd1, 32'h0BAD_0001);
    send_list_word(MODE_INSERT, POS_W'(LIST_CAP + 1), 32'h0BAD_0002);
    send_list_word(MODE_INSERT, POS_W'(LIST_CAP + 2), 32'h0BAD_0003);
    send_list_word(MODE_INSERT, 8'd0, 32'h0BAD_0004);
    send_list_word(MODE_READ, 8'd1, 32'h0);
    send_list_word(MODE_READ, POS_W'(LIST_CAP), 32'h0);
    send_list_word(MODE_READ, POS_W'(LIST_CAP + 1), 32'h0);
    send_list_word(MODE_READ, 8'd255, 32'h0);
    wait_results_drained();
  endtask

  // random words against the full list
  task automatic test_random_full();
    send_random_words(180, 70);
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges_directed();
    test_random_growth();
    test_back_to_back();
    test_output_stall();
    test_fill_to_capacity();
    test_random_full();

    // let any stray result word show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d inserts and %0d reads, %0d result words checked, final length %0d",
             inserts_sent, reads_sent, results_checked, list_len);
    $display("edges, random growth, back to back, long output stall, full list probes");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
